### design/assert_macros.svh
// Assertion macros for the design files; the receiver core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### design/crlfsd_pkg.sv
// Types and constants for the CR-LF frame receiver with speed decode.
package crlfsd_pkg;

    localparam int MAX_FRAME_BYTES = 200;
    localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
    localparam int HEAD_DEPTH      = 8;
    localparam int HEAD_IDX_W      = $clog2(HEAD_DEPTH);
    localparam int LEN_W           = 6;
    localparam int SPEED_W         = 19;

    localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = LEN_W'(16);

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_CONSUME = 1'b1;

    localparam logic [SPEED_W-1:0] WEIGHT_THOUSANDS = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0] WEIGHT_HUNDREDS  = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] WEIGHT_TENS      = SPEED_W'(10);

    typedef logic [3:0][7:0] t_digits;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic               frame_ok;
        logic               frame_error;
        logic               speeds_valid;
        logic [SPEED_W-1:0] right_speed_tenths;
        logic [SPEED_W-1:0] left_speed_tenths;
    } t_out_item;

endpackage

### design/crlfsd_speed_decode.sv
// Decodes four payload bytes into a speed: b0*1000 + b1*100 + b2*10 + b3.
module crlfsd_speed_decode (
    input  crlfsd_pkg::t_digits                i_digits,
    output logic [crlfsd_pkg::SPEED_W-1:0]     o_speed
);

    // Largest value is 255 * 1111, which fits the speed width without wrap.
    assign o_speed = crlfsd_pkg::SPEED_W'(i_digits[0]) * crlfsd_pkg::WEIGHT_THOUSANDS
                   + crlfsd_pkg::SPEED_W'(i_digits[1]) * crlfsd_pkg::WEIGHT_HUNDREDS
                   + crlfsd_pkg::SPEED_W'(i_digits[2]) * crlfsd_pkg::WEIGHT_TENS
                   + crlfsd_pkg::SPEED_W'(i_digits[3]);

endmodule

### design/crlf_frame_receiver_speed_decode_core.sv
// Top level of the CR-LF frame receiver with wheel-speed decode.
// Each input transaction carries either a received byte or a consume command and yields
// exactly one result transaction. The block takes one transaction per clock while its results
// are taken. An accepted transaction is held in the input register, and the single-pass update
// and decode logic then writes the result register, which presents the result. The rate
// is set by that update path, which handles a byte or a consume in a single pass; a result
// held by a stalled receiver stops the input once the input register is also occupied.
// The frame length register should only be written while no transaction is in flight. The
// first eight payload bytes are kept for the decode and carry no reset; no clearing pass
// is needed.
`include "assert_macros.svh"

module crlf_frame_receiver_speed_decode_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [crlfsd_pkg::LEN_W-1:0]         i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  crlfsd_pkg::t_in_item                 i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output crlfsd_pkg::t_out_item                o_out_item
);

    logic [crlfsd_pkg::LEN_W-1:0]   r_frame_length;
    logic                           r_in_valid;
    crlfsd_pkg::t_in_item           r_in_item;
    logic                           r_out_valid;
    crlfsd_pkg::t_out_item          r_out_item;
    logic [crlfsd_pkg::COUNT_W-1:0] r_byte_count;
    logic                           r_cr_seen;
    logic                           r_frame_complete;
    logic [7:0]                     r_head [crlfsd_pkg::HEAD_DEPTH];

    logic [crlfsd_pkg::COUNT_W-1:0] n_byte_count;
    logic                           n_cr_seen;
    logic                           n_frame_complete;
    crlfsd_pkg::t_out_item          n_out_item;
    logic                           n_head_we;

    logic [crlfsd_pkg::COUNT_W-1:0] count_inc;
    logic                           out_free;
    logic                           advance;
    crlfsd_pkg::t_digits            right_digits;
    crlfsd_pkg::t_digits            left_digits;
    logic [crlfsd_pkg::SPEED_W-1:0] right_speed;
    logic [crlfsd_pkg::SPEED_W-1:0] left_speed;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            right_digits[i] = r_head[i];
            left_digits[i]  = r_head[i + 4];
        end
    end

    crlfsd_speed_decode u_right_dec (
        .i_digits (right_digits),
        .o_speed  (right_speed)
    );

    crlfsd_speed_decode u_left_dec (
        .i_digits (left_digits),
        .o_speed  (left_speed)
    );

    assign count_inc = r_byte_count + crlfsd_pkg::COUNT_W'(1);

    always_comb begin
        n_byte_count     = r_byte_count;
        n_cr_seen        = r_cr_seen;
        n_frame_complete = r_frame_complete;
        n_out_item       = '0;
        n_head_we        = 1'b0;
        if (r_in_item.command == crlfsd_pkg::CMD_CONSUME) begin
            if (r_frame_complete) begin
                n_out_item.speeds_valid       = 1'b1;
                n_out_item.right_speed_tenths = right_speed;
                n_out_item.left_speed_tenths  = left_speed;
                n_byte_count     = '0;
                n_cr_seen        = 1'b0;
                n_frame_complete = 1'b0;
            end
        end else if (!r_frame_complete) begin
            if (r_cr_seen) begin
                if (r_in_item.rx_byte == crlfsd_pkg::CHAR_LF &&
                    r_byte_count == crlfsd_pkg::COUNT_W'(r_frame_length)) begin
                    n_frame_complete    = 1'b1;
                    n_cr_seen           = 1'b0;
                    n_out_item.frame_ok = 1'b1;
                end else begin
                    n_out_item.frame_error = 1'b1;
                    n_byte_count = '0;
                    n_cr_seen    = 1'b0;
                end
            end else if (r_in_item.rx_byte == crlfsd_pkg::CHAR_CR) begin
                n_cr_seen = 1'b1;
            end else begin
                n_head_we = (r_byte_count < crlfsd_pkg::COUNT_W'(crlfsd_pkg::HEAD_DEPTH));
                if (count_inc >= crlfsd_pkg::COUNT_W'(crlfsd_pkg::MAX_FRAME_BYTES)) begin
                    // overflow: drop the frame
                    n_out_item.frame_error = 1'b1;
                    n_byte_count = '0;
                end else begin
                    n_byte_count = count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length   <= crlfsd_pkg::FRAME_LENGTH_RESET;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_byte_count     <= '0;
            r_cr_seen        <= 1'b0;
            r_frame_complete <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_length <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid      <= 1'b1;
                r_byte_count     <= n_byte_count;
                r_cr_seen        <= n_cr_seen;
                r_frame_complete <= n_frame_complete;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
        if (advance && n_head_we) begin
            r_head[r_byte_count[crlfsd_pkg::HEAD_IDX_W-1:0]] <= r_in_item.rx_byte;
        end
    end

    `ASSERT_CLK(a_count_below_max,
        r_byte_count < crlfsd_pkg::COUNT_W'(crlfsd_pkg::MAX_FRAME_BYTES),
        "byte count reached the overflow limit")
    `ASSERT_CLK(a_complete_clears_cr, r_frame_complete |-> !r_cr_seen,
        "CR pending while a frame is complete")
    `ASSERT_CLK(a_result_kinds_exclusive,
        r_out_valid |-> ($countones({r_out_item.frame_ok, r_out_item.frame_error,
                                      r_out_item.speeds_valid}) <= 1),
        "result carries more than one event flag")
    `ASSERT_CLK(a_ok_sets_complete,
        advance && n_out_item.frame_ok |=> r_frame_complete,
        "valid frame did not leave the frame complete")

endmodule

### dv/tb_crlf_frame_receiver_speed_decode_core.sv
// Testbench for the CR-LF frame receiver with wheel-speed decode: random and directed traffic.
`timescale 1ns / 100ps

module tb_crlf_frame_receiver_speed_decode_core;
    import crlfsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [LEN_W-1:0]    cfg_data;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in_item            in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_item;

    crlf_frame_receiver_speed_decode_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Byte and consume transactions waiting to be driven, and decodes still owed by the block
    t_in_item  rx_stream_q[$];
    t_out_item decoded_q[$];

    int  queued;
    int  errors;
    int  cycles;
    int  send_gap_pct;
    int  recv_stall_pct;
    bit  in_taken = 1'b0;

    // Receiver state as the block should hold it
    logic [LEN_W-1:0]   rx_len      = FRAME_LENGTH_RESET;
    logic [COUNT_W-1:0] rx_count    = '0;
    logic               rx_cr_seen  = 1'b0;
    logic               rx_complete = 1'b0;
    logic [7:0]         rx_head[HEAD_DEPTH];

    function automatic void rx_restart();
        rx_count    = '0;
        rx_cr_seen  = 1'b0;
        rx_complete = 1'b0;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_of(input int base);
        int sum;
        sum = int'(rx_head[base]) * 1000 + int'(rx_head[base + 1]) * 100
            + int'(rx_head[base + 2]) * 10 + int'(rx_head[base + 3]);
        return sum[SPEED_W-1:0];
    endfunction

    function automatic t_out_item receive_step(input t_in_item it);
        t_out_item r;
        r = '0;
        if (it.command == CMD_CONSUME) begin
            if (rx_complete) begin
                r.speeds_valid       = 1'b1;
                r.right_speed_tenths = speed_of(0);
                r.left_speed_tenths  = speed_of(4);
                rx_restart();
            end
        end else if (!rx_complete) begin
            if (rx_cr_seen) begin
                if (it.rx_byte == CHAR_LF && rx_count == COUNT_W'(rx_len)) begin
                    rx_complete = 1'b1;
                    r.frame_ok  = 1'b1;
                end else begin
                    r.frame_error = 1'b1;
                    rx_restart();
                end
            end else if (it.rx_byte == CHAR_CR) begin
                rx_cr_seen = 1'b1;
            end else begin
                if (rx_count < HEAD_DEPTH)
                    rx_head[rx_count[HEAD_IDX_W-1:0]] = it.rx_byte;
                rx_count = rx_count + 1'b1;
                if (rx_count >= MAX_FRAME_BYTES) begin
                    r.frame_error = 1'b1;
                    rx_restart();
                end
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Accepted transactions and register writes update the prediction at the rising edge
    always @(posedge clk) begin : predict
        in_taken = 1'b0;
        if (rst_n && cfg_we)
            rx_len = cfg_data;
        if (rst_n && in_valid && in_ready) begin
            decoded_q.push_back(receive_step(in_item));
            in_taken = 1'b1;
        end
    end

    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (decoded_q.size() == 0) begin
                note_mismatch($sformatf("result with nothing outstanding: %h", out_item));
            end else begin
                want = decoded_q.pop_front();
                if (out_item.frame_ok !== want.frame_ok)
                    note_mismatch($sformatf("frame_ok got %b want %b",
                                            out_item.frame_ok, want.frame_ok));
                if (out_item.frame_error !== want.frame_error)
                    note_mismatch($sformatf("frame_error got %b want %b",
                                            out_item.frame_error, want.frame_error));
                if (out_item.speeds_valid !== want.speeds_valid)
                    note_mismatch($sformatf("speeds_valid got %b want %b",
                                            out_item.speeds_valid, want.speeds_valid));
                if (out_item.right_speed_tenths !== want.right_speed_tenths)
                    note_mismatch($sformatf("right_speed_tenths got %0d want %0d",
                                            out_item.right_speed_tenths,
                                            want.right_speed_tenths));
                if (out_item.left_speed_tenths !== want.left_speed_tenths)
                    note_mismatch($sformatf("left_speed_tenths got %0d want %0d",
                                            out_item.left_speed_tenths,
                                            want.left_speed_tenths));
            end
        end
    end

    always @(negedge clk) begin : drive
        if (!in_valid || in_taken) begin
            if (rst_n && rx_stream_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                in_item  <= rx_stream_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL crlf_frame_receiver_speed_decode_core");
            $finish;
        end
    end

    task automatic queue_item(input logic cmd, input logic [7:0] b);
        t_in_item it;
        it.command = cmd;
        it.rx_byte = b;
        rx_stream_q.push_back(it);
        queued++;
    endtask

    // Any byte but CR, so it lands in the payload
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_CR)
            b = 8'($urandom_range(14, 255));
        return b;
    endfunction

    task automatic write_frame_length(input logic [LEN_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        while (rx_stream_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly clean frames with random payload; some bad lengths, broken tails and noise
    task automatic push_traffic(input int budget, input int len);
        int stop;
        int n;
        int roll;
        logic [7:0] b;
        stop = queued + budget;
        while (queued < stop) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                n = len;
                if ($urandom_range(0, 9) == 0)
                    n = (len == 0 || $urandom_range(0, 1) == 1) ? len + 1 : len - 1;
                repeat (n) queue_item(CMD_BYTE, payload_byte());
                queue_item(CMD_BYTE, CHAR_CR);
                queue_item(CMD_BYTE, ($urandom_range(0, 9) != 0) ? CHAR_LF
                                                              : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        queue_item(CMD_BYTE, 8'($urandom_range(0, 255)));
                queue_item(CMD_CONSUME, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    queue_item(CMD_CONSUME, 8'($urandom_range(0, 255)));
            end else if (roll < 85) begin
                repeat ($urandom_range(0, 4)) queue_item(CMD_BYTE, payload_byte());
                queue_item(CMD_BYTE, CHAR_CR);
                b = payload_byte();
                queue_item(CMD_BYTE, (b == CHAR_LF) ? CHAR_CR : b);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: b = CHAR_CR;
                        1: b = CHAR_LF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    queue_item(($urandom_range(0, 3) == 0) ? CMD_CONSUME : CMD_BYTE, b);
                end
            end
        end
    endtask

    task automatic run_phase(input int len, input int send_pct, input int recv_pct,
                             input int budget);
        write_frame_length(LEN_W'(len));
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        push_traffic(budget, len);
        drain();
    endtask

    initial begin
        int i;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        queued         = 0;
        errors         = 0;
        cycles         = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: default length of 16, no idling
        queue_item(CMD_CONSUME, 8'h00);               // nothing complete yet
        for (i = 0; i < 16; i++)
            queue_item(CMD_BYTE, (i < 4) ? 8'hff : (i < 8) ? 8'h00 : (i == 8) ? CHAR_LF
                                 : 8'(8'h80 + i));
        queue_item(CMD_BYTE, CHAR_CR);
        queue_item(CMD_BYTE, CHAR_LF);
        queue_item(CMD_BYTE, 8'h41);                  // ignored while the frame is held
        queue_item(CMD_CONSUME, 8'hff);               // right at its maximum, left zero
        queue_item(CMD_BYTE, CHAR_CR);
        queue_item(CMD_BYTE, CHAR_LF);                // count short
        queue_item(CMD_BYTE, CHAR_CR);
        queue_item(CMD_BYTE, CHAR_CR);                // second CR
        drain();

        // Zero-length frame decodes whatever the head still holds
        write_frame_length('0);
        queue_item(CMD_BYTE, CHAR_CR);
        queue_item(CMD_BYTE, CHAR_LF);
        queue_item(CMD_CONSUME, 8'h00);
        drain();

        run_phase(8, 0, 0, 110);
        write_frame_length(LEN_W'(63));
        send_gap_pct   = 0;
        recv_stall_pct = 46;
        repeat (MAX_FRAME_BYTES) queue_item(CMD_BYTE, payload_byte());   // overflow
        push_traffic(100, 63);
        drain();
        run_phase($urandom_range(8, 63), 46, 0, 110);
        run_phase($urandom_range(0, 7), 6, 6, 80);
        run_phase($urandom_range(0, 63), 46, 46, 80);
        run_phase($urandom_range(8, 63), 0, 0, 80);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS crlf_frame_receiver_speed_decode_core");
        else
            $display("FAIL crlf_frame_receiver_speed_decode_core");
        $finish;
    end

endmodule

### crlf_frame_receiver_speed_decode_core.f
+incdir+design
design/crlfsd_pkg.sv
design/crlfsd_speed_decode.sv
design/crlf_frame_receiver_speed_decode_core.sv
dv/tb_crlf_frame_receiver_speed_decode_core.sv
